### design/position_to_speed_estimator_macros.svh
// Assertion helpers for the checker file.
`ifndef POSITION_TO_SPEED_ESTIMATOR_MACROS_SVH
`define POSITION_TO_SPEED_ESTIMATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pse_pkg.sv
package pse_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned RATE_W     = 16;
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd200;

  // Speeds averaged per axis: the current one and WINDOW-1 older ones.
  // WINDOW is a power of two, so the mean drops the low REM_W bits of the sum.
  localparam int unsigned WINDOW     = 4;
  localparam int unsigned SUM_W      = DATA_W + $clog2(WINDOW);
  localparam int unsigned REM_W      = $clog2(WINDOW);
  localparam int unsigned PROD_W     = DATA_W + RATE_W;

  // Bit-serial square root: one result bit per step.
  localparam int unsigned SQ_W       = 2 * DATA_W;
  localparam int unsigned ROOT_REM_W = DATA_W + 2;
  localparam int unsigned ROOT_CNT_W = $clog2(DATA_W);

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] avg_y;
    logic [DATA_W-1:0] avg_x;
  } pse_avg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pse_fifo_st_t;

endpackage

### design/pse_front.sv
module pse_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pse_pkg::RATE_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pse_pkg::DATA_W-1:0]  pos_x_i,
  input  logic [pse_pkg::DATA_W-1:0]  pos_y_i,
  output logic                        push_o,
  output pse_pkg::pse_avg_t           push_data_o,
  input  pse_pkg::pse_fifo_st_t       fifo_st_i
);
  import pse_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_SUM  = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_e;

  front_state_e          state_q, state_d;
  logic [RATE_W-1:0]     rate_q, rate_d;
  logic [DATA_W-1:0]     last_q [2];
  logic [DATA_W-1:0]     last_d [2];
  logic [DATA_W-1:0]     diff_q [2];
  logic [DATA_W-1:0]     diff_d [2];
  logic [DATA_W-1:0]     spd_q [2];
  logic [DATA_W-1:0]     spd_d [2];
  logic                  sat_q, sat_d;
  logic [DATA_W-1:0]     hist_q [2][WINDOW-1];
  logic [DATA_W-1:0]     hist_d [2][WINDOW-1];
  logic [SUM_W-1:0]      hsum_q [2];
  logic [SUM_W-1:0]      hsum_d [2];
  logic [DATA_W-1:0]     div_q [2];
  logic [DATA_W-1:0]     div_d [2];

  logic [DATA_W-1:0]     pos [2];
  logic [DATA_W:0]       sub [2];
  logic [PROD_W-1:0]     prod [2];
  logic [SUM_W-1:0]      total [2];
  logic                  clip;

  assign in_ready_o        = (state_q == F_IDLE);
  assign push_o            = (state_q == F_PUSH) && !fifo_st_i.full;
  assign push_data_o.avg_x = div_q[0];
  assign push_data_o.avg_y = div_q[1];
  assign push_data_o.sat   = sat_q;

  always_comb begin
    pos[0] = pos_x_i;
    pos[1] = pos_y_i;
    for (int a = 0; a < 2; a++) begin
      sub[a]   = {pos[a][DATA_W-1], pos[a]} - {last_q[a][DATA_W-1], last_q[a]};
      prod[a]  = PROD_W'(diff_q[a]) * PROD_W'(rate_q);
      total[a] = hsum_q[a] + SUM_W'(spd_q[a]);
    end
    clip = (|prod[0][PROD_W-1:DATA_W]) || (|prod[1][PROD_W-1:DATA_W]);
  end

  always_comb begin
    state_d = state_q;
    rate_d  = cfg_we_i ? cfg_wdata_i : rate_q;
    last_d  = last_q;
    diff_d  = diff_q;
    spd_d   = spd_q;
    sat_d   = sat_q;
    hist_d  = hist_q;
    hsum_d  = hsum_q;
    div_d   = div_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          for (int a = 0; a < 2; a++) begin
            last_d[a] = pos[a];
            // absolute difference always fits in DATA_W bits
            diff_d[a] = sub[a][DATA_W] ? DATA_W'(-sub[a]) : sub[a][DATA_W-1:0];
          end
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        sat_d = clip;
        for (int a = 0; a < 2; a++) begin
          spd_d[a] = (|prod[a][PROD_W-1:DATA_W]) ? '1 : prod[a][DATA_W-1:0];
        end
        state_d = F_SUM;
      end
      F_SUM: begin
        for (int a = 0; a < 2; a++) begin
          // divide by the window length: drop the low bits of the sum
          div_d[a]  = total[a][SUM_W-1:REM_W];
          // running sum drops the oldest speed and takes the new one
          hsum_d[a] = total[a] - SUM_W'(hist_q[a][WINDOW-2]);
          for (int i = WINDOW - 2; i > 0; i--) begin
            hist_d[a][i] = hist_q[a][i-1];
          end
          hist_d[a][0] = spd_q[a];
        end
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!fifo_st_i.full) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      rate_q  <= RATE_RESET;
      last_q  <= '{default: '0};
      hist_q  <= '{default: '0};
      hsum_q  <= '{default: '0};
    end else begin
      state_q <= state_d;
      rate_q  <= rate_d;
      last_q  <= last_d;
      hist_q  <= hist_d;
      hsum_q  <= hsum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    spd_q  <= spd_d;
    sat_q  <= sat_d;
    div_q  <= div_d;
  end

endmodule

### design/pse_fifo.sv
module pse_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  pse_pkg::pse_avg_t      push_data_i,
  input  logic                   pop_i,
  output pse_pkg::pse_avg_t      pop_data_o,
  output pse_pkg::pse_fifo_st_t  st_o
);
  import pse_pkg::*;

  pse_avg_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_q, wr_d;
  logic [FIFO_PTR_W-1:0]  rd_q, rd_d;
  logic [FIFO_CNT_W-1:0]  cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign st_o.full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign st_o.empty = (cnt_q == '0);
  assign do_push    = push_i && !st_o.full;
  assign do_pop     = pop_i && !st_o.empty;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### design/pse_back.sv
module pse_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  output logic                          pop_o,
  input  pse_pkg::pse_avg_t             pop_data_i,
  input  pse_pkg::pse_fifo_st_t         fifo_st_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [3*pse_pkg::DATA_W-1:0]  out_data_o,
  output logic                          out_sat_o
);
  import pse_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_SQR  = 5'b00010,
    B_ADD  = 5'b00100,
    B_ROOT = 5'b01000,
    B_DONE = 5'b10000
  } back_state_e;

  back_state_e            state_q, state_d;
  pse_avg_t               ent_q, ent_d;
  logic [SQ_W-1:0]        sqx_q, sqx_d;
  logic [SQ_W-1:0]        sqy_q, sqy_d;
  logic [SQ_W-1:0]        rad_q, rad_d;
  logic [ROOT_REM_W-1:0]  rem_q, rem_d;
  logic [DATA_W-1:0]      root_q, root_d;
  logic [ROOT_CNT_W-1:0]  cnt_q, cnt_d;
  logic                   msat_q, msat_d;
  logic                   ovalid_q, ovalid_d;
  logic [3*DATA_W-1:0]    odata_q, odata_d;
  logic                   osat_q, osat_d;

  logic [SQ_W:0]          sq_sum;
  logic [ROOT_REM_W+1:0]  rem_t;
  logic [ROOT_REM_W+1:0]  trial;
  logic                   ge;
  logic                   out_free;

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
  assign out_sat_o   = osat_q;
  assign out_free    = !ovalid_q || out_ready_i;
  assign pop_o       = (state_q == B_IDLE) && !fifo_st_i.empty;

  always_comb begin
    sq_sum = {1'b0, sqx_q} + {1'b0, sqy_q};
    rem_t  = {rem_q, rad_q[SQ_W-1:SQ_W-2]};
    trial  = (ROOT_REM_W+2)'({root_q, 2'b01});
    ge     = (rem_t >= trial);
  end

  always_comb begin
    state_d  = state_q;
    ent_d    = ent_q;
    sqx_d    = sqx_q;
    sqy_d    = sqy_q;
    rad_d    = rad_q;
    rem_d    = rem_q;
    root_d   = root_q;
    cnt_d    = cnt_q;
    msat_d   = msat_q;
    odata_d  = odata_q;
    osat_d   = osat_q;
    ovalid_d = ovalid_q && !out_ready_i;
    unique case (state_q)
      B_IDLE: begin
        if (!fifo_st_i.empty) begin
          ent_d   = pop_data_i;
          state_d = B_SQR;
        end
      end
      B_SQR: begin
        sqx_d   = SQ_W'(ent_q.avg_x) * SQ_W'(ent_q.avg_x);
        sqy_d   = SQ_W'(ent_q.avg_y) * SQ_W'(ent_q.avg_y);
        state_d = B_ADD;
      end
      B_ADD: begin
        cnt_d = '0;
        if (sq_sum[SQ_W]) begin
          // sum of squares beyond 64 bits: clip the magnitude
          root_d  = '1;
          msat_d  = 1'b1;
          state_d = B_DONE;
        end else begin
          rad_d   = sq_sum[SQ_W-1:0];
          rem_d   = '0;
          root_d  = '0;
          msat_d  = 1'b0;
          state_d = B_ROOT;
        end
      end
      B_ROOT: begin
        rem_d  = ge ? ROOT_REM_W'(rem_t - trial) : ROOT_REM_W'(rem_t);
        root_d = {root_q[DATA_W-2:0], ge};
        rad_d  = {rad_q[SQ_W-3:0], 2'b00};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == ROOT_CNT_W'(DATA_W - 1)) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          odata_d  = {root_q, ent_q.avg_y, ent_q.avg_x};
          osat_d   = ent_q.sat || msat_q;
          ovalid_d = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q   <= ent_d;
    sqx_q   <= sqx_d;
    sqy_q   <= sqy_d;
    rad_q   <= rad_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    msat_q  <= msat_d;
    odata_q <= odata_d;
    osat_q  <= osat_d;
  end

endmodule

### design/position_to_speed_estimator.sv
// Channel   Direction  Handshake               Content
// s_axis    in         s_axis_tvalid/tready    pos_x, pos_y
// m_axis    out        m_axis_tvalid/tready    avg_speed_x, avg_speed_y, speed_magnitude;
//                                              saturated in tuser
// cfg       in         cfg_we_i                rate_scale
//
// The front end takes one input transaction at a time and pushes it once the queue has room:
// accept, multiply by rate_scale, sum and shift by the window length, push.
// The back end works on one result at a time, mostly in the 32-step square root, and pops
// the next queue entry only after handing the last result to its output register.
// A two-entry queue between the two ends lets the front take new samples while the
// back works and while a finished result waits on m_axis_tready.
// rst_ni clears positions, speed history, the queue and m_axis_tvalid at once; rate_scale resets to 200.
module position_to_speed_estimator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pse_pkg::RATE_W-1:0]    cfg_wdata_i,    // rate_scale
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [2*pse_pkg::DATA_W-1:0]  s_axis_tdata,   // pos_x, pos_y
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [3*pse_pkg::DATA_W-1:0]  m_axis_tdata,   // avg_speed_x, avg_speed_y,
                                                        // speed_magnitude
  output logic [0:0]                    m_axis_tuser    // saturated
);
  import pse_pkg::*;

  logic          push;
  pse_avg_t      push_data;
  logic          pop;
  pse_avg_t      pop_data;
  pse_fifo_st_t  fifo_st;
  logic          out_sat;

  pse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pos_x_i     (s_axis_tdata[DATA_W-1:0]),
    .pos_y_i     (s_axis_tdata[2*DATA_W-1:DATA_W]),
    .push_o      (push),
    .push_data_o (push_data),
    .fifo_st_i   (fifo_st)
  );

  pse_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .st_o        (fifo_st)
  );

  pse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .fifo_st_i   (fifo_st),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_sat_o   (out_sat)
  );

  assign m_axis_tuser[0] = out_sat;

endmodule

### design/pse_checker.sv
`include "position_to_speed_estimator_macros.svh"

module pse_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [3*pse_pkg::DATA_W-1:0]  m_axis_tdata,
  input logic [0:0]                    m_axis_tuser
);
  import pse_pkg::*;

  logic [DATA_W-1:0] avg_x;
  logic [DATA_W-1:0] avg_y;
  logic [DATA_W-1:0] mag;
  logic [DATA_W:0]   avg_sum;
  logic [3*DATA_W:0] out_word;
  logic              stall;

  assign avg_x    = m_axis_tdata[DATA_W-1:0];
  assign avg_y    = m_axis_tdata[2*DATA_W-1:DATA_W];
  assign mag      = m_axis_tdata[3*DATA_W-1:2*DATA_W];
  assign avg_sum  = {1'b0, avg_x} + {1'b0, avg_y};
  assign out_word = {m_axis_tuser, m_axis_tdata};
  assign stall    = m_axis_tvalid && !m_axis_tready;

  // hold a stalled result
  `PSE_ASSERT_NXT(a_out_hold, stall, m_axis_tvalid, "result dropped while stalled")
  `PSE_ASSERT_NXT(a_out_stable, stall, $stable(out_word), "result changed while stalled")
  // magnitude is never below either axis average
  `PSE_ASSERT_IMP(a_mag_low, m_axis_tvalid, (mag >= avg_x) && (mag >= avg_y), "magnitude too low")
  // and never above their sum
  `PSE_ASSERT_IMP(a_mag_high, m_axis_tvalid, ({1'b0, mag} <= avg_sum), "magnitude above sum")

endmodule

bind position_to_speed_estimator pse_checker u_pse_checker (.*);
